@@ design/wpm_pkg.sv @@
// shared types, codes and constants of the wildcard pattern matcher
package wpm_pkg;

  // default sizes handed to the top level parameters
  localparam int unsigned MAX_PATTERN_DEF   = 64;
  localparam int unsigned POSITION_BITS_DEF = 32;

  // queue depths between front, back and result side
  localparam int unsigned MID_DEPTH = 4;
  localparam int unsigned OUT_DEPTH = 4;

  // fixed field widths
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned START_W = 32;

  // pattern byte that matches any text byte ('?')
  localparam logic [CHAR_W-1:0] WILDCARD_CHAR = 8'd63;

  // input kind codes
  localparam logic [KIND_W-1:0] KIND_RESTART = 2'd0;
  localparam logic [KIND_W-1:0] KIND_APPEND  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TEXT    = 2'd2;

  // classified operation passed from front to back
  typedef enum logic [1:0] {
    OP_RESTART,
    OP_APPEND,
    OP_TEXT
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [CHAR_W-1:0] ch;
  } op_t;

  // one result item
  typedef struct packed {
    logic [START_W-1:0] match_start;
    logic               overflow_error;
  } res_t;

endpackage

@@ design/wpm_fifo.sv @@
// small register queue used between the parts of the matcher
module wpm_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           data_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           data_o,
  output logic                       full_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ design/wpm_front.sv @@
// front part: takes input items, classifies them and queues them for the back
module wpm_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  output logic                       full_o,
  input  logic [wpm_pkg::KIND_W-1:0] kind_i,
  input  logic [wpm_pkg::CHAR_W-1:0] char_value_i,
  output logic                       op_valid_o,
  output wpm_pkg::op_t               op_o,
  input  logic                       op_ready_i
);
  import wpm_pkg::*;

  op_t                          op_in;
  logic                         op_known;
  logic                         q_empty;
  logic [$bits(op_t)-1:0]       q_rdata;
  logic [$clog2(MID_DEPTH+1)-1:0] q_count;

  // decode the kind field; the unused code is taken and dropped
  always_comb begin
    op_in.ch = char_value_i;
    op_in.op = OP_TEXT;
    op_known = 1'b1;
    case (kind_i)
      KIND_RESTART: op_in.op = OP_RESTART;
      KIND_APPEND:  op_in.op = OP_APPEND;
      KIND_TEXT:    op_in.op = OP_TEXT;
      default:      op_known = 1'b0;
    endcase
  end

  // queue of classified items toward the back
  wpm_fifo #(
    .WIDTH($bits(op_t)),
    .DEPTH(MID_DEPTH)
  ) u_mid_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i && op_known),
    .data_i (op_in),
    .pop_i  (op_ready_i),
    .data_o (q_rdata),
    .full_o (full_o),
    .empty_o(q_empty),
    .count_o(q_count)
  );

  assign op_valid_o = !q_empty;
  assign op_o       = op_t'(q_rdata);

  // assertions
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= ($clog2(MID_DEPTH+1))'(MID_DEPTH))
    else $error("mid queue count beyond depth");
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !op_ready_i |=> full_o)
    else $error("mid queue lost an item while stalled");
  a_valid_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_valid_o == (q_count != '0))
    else $error("mid queue valid disagrees with count");

endmodule

@@ design/wpm_back.sv @@
// back part: pattern and text shift lines, parallel window compare, result staging
module wpm_back #(
  parameter int unsigned MAX_PATTERN   = wpm_pkg::MAX_PATTERN_DEF,
  parameter int unsigned POSITION_BITS = wpm_pkg::POSITION_BITS_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     op_valid_i,
  input  wpm_pkg::op_t                             op_i,
  output logic                                     op_ready_o,
  input  logic [$clog2(wpm_pkg::OUT_DEPTH+1)-1:0]  out_count_i,
  output logic                                     res_valid_o,
  output wpm_pkg::res_t                            res_o
);
  import wpm_pkg::*;

  localparam int unsigned LW  = $clog2(MAX_PATTERN + 1);
  localparam int unsigned CW  = (POSITION_BITS > LW) ? POSITION_BITS : LW;
  localparam int unsigned OCW = $clog2(OUT_DEPTH + 1) + 1;

  // lane k of the pattern line holds pattern byte (length-1-k)
  logic [CHAR_W-1:0]        pat_q  [MAX_PATTERN];
  logic [CHAR_W-1:0]        txt_q  [MAX_PATTERN];
  logic [CHAR_W-1:0]        txt_sh [MAX_PATTERN];
  logic [MAX_PATTERN-1:0]   en_q, en_d;
  logic [LW-1:0]            len_q, len_d;
  logic [POSITION_BITS-1:0] cnt_q, cnt_d;
  logic [POSITION_BITS-1:0] cnt_inc;
  logic [MAX_PATTERN-1:0]   hit_d, hit_q;
  logic                     fire, pat_shift, txt_shift, at_limit, pat_full;
  logic                     s2_valid_q, s2_valid_d, s2_ovf_q, s2_ovf_d;
  logic [START_W-1:0]       s2_start_q, s2_start_d;
  logic [CW-1:0]            start_full;

  // room in the result queue for this item and the one staged
  assign op_ready_o = (OCW'(out_count_i) + OCW'(s2_valid_q)) < OCW'(OUT_DEPTH);
  assign fire       = op_valid_i && op_ready_o;

  assign at_limit   = &cnt_q;
  assign pat_full   = (len_q == LW'(MAX_PATTERN));
  assign cnt_inc    = cnt_q + 1'b1;
  assign start_full = CW'(cnt_inc) - CW'(len_q);
  assign pat_shift  = fire && (op_i.op == OP_APPEND) && !pat_full;
  assign txt_shift  = fire && (op_i.op == OP_TEXT) && !at_limit;

  // per-lane shift and compare against the window ending at the new byte
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_lane
    if (k == 0) begin : g_head
      assign txt_sh[k] = op_i.ch;
      always_ff @(posedge clk_i) begin
        if (pat_shift) begin
          pat_q[k] <= op_i.ch;
        end
      end
      assign en_d[k] = 1'b1;
    end else begin : g_body
      assign txt_sh[k] = txt_q[k-1];
      always_ff @(posedge clk_i) begin
        if (pat_shift) begin
          pat_q[k] <= pat_q[k-1];
        end
      end
      assign en_d[k] = en_q[k-1];
    end
    always_ff @(posedge clk_i) begin
      if (txt_shift) begin
        txt_q[k] <= txt_sh[k];
      end
    end
    assign hit_d[k] = !en_q[k] || (pat_q[k] == WILDCARD_CHAR) || (pat_q[k] == txt_sh[k]);
  end

  // length, count and result staging
  always_comb begin
    len_d      = len_q;
    cnt_d      = cnt_q;
    s2_valid_d = 1'b0;
    s2_ovf_d   = 1'b0;
    s2_start_d = START_W'(start_full);
    if (fire) begin
      case (op_i.op)
        OP_RESTART: begin
          len_d = '0;
          cnt_d = '0;
        end
        OP_APPEND: begin
          if (pat_full) begin
            s2_valid_d = 1'b1;
            s2_ovf_d   = 1'b1;
            s2_start_d = '0;
          end else begin
            len_d = len_q + 1'b1;
          end
        end
        OP_TEXT: begin
          if (!at_limit) begin
            cnt_d      = cnt_inc;
            s2_valid_d = (len_q != '0) && (CW'(cnt_inc) >= CW'(len_q));
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      cnt_q      <= '0;
      en_q       <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      len_q      <= len_d;
      cnt_q      <= cnt_d;
      s2_valid_q <= s2_valid_d;
      if (fire && (op_i.op == OP_RESTART)) begin
        en_q <= '0;
      end else if (pat_shift) begin
        en_q <= en_d;
      end
    end
  end

  // staged payload
  always_ff @(posedge clk_i) begin
    s2_ovf_q   <= s2_ovf_d;
    s2_start_q <= s2_start_d;
    hit_q      <= hit_d;
  end

  // reduce the lane hits into one result
  assign res_valid_o          = s2_valid_q && (s2_ovf_q || (&hit_q));
  assign res_o.match_start    = s2_start_q;
  assign res_o.overflow_error = s2_ovf_q;

  // assertions
  a_mask_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(en_q) == int'(len_q))
    else $error("lane enables disagree with pattern length");
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && s2_ovf_q |-> pat_full)
    else $error("overflow flagged with room in the pattern");
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (op_i.op == OP_RESTART) |=> (len_q == '0) && (cnt_q == '0) && !s2_valid_q)
    else $error("restart left state behind");
  a_window_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && !s2_ovf_q |-> (len_q != '0) && (CW'(cnt_q) >= CW'(len_q)))
    else $error("window compared before enough text arrived");

endmodule

@@ design/wildcard_pattern_matcher_top.sv @@
// Wildcard pattern matcher top level: front classifier, back compare engine, result queue.
// Throughput: one item per cycle unless the item queue is full or the result queue lacks room;
//   the back compares all pattern lanes in parallel each cycle. A pushed item reaches its
//   result (if any) through the item queue, the compare stage and the result queue.
// Reset: asynchronous active low; pattern length, text count and queues clear at once,
//   no clearing pass is needed.
module wildcard_pattern_matcher_top #(
  parameter int unsigned MAX_PATTERN   = wpm_pkg::MAX_PATTERN_DEF,
  parameter int unsigned POSITION_BITS = wpm_pkg::POSITION_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [wpm_pkg::KIND_W-1:0]  kind_i,
  input  logic [wpm_pkg::CHAR_W-1:0]  char_value_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [wpm_pkg::START_W-1:0] match_start_o,
  output logic                        overflow_error_o
);
  import wpm_pkg::*;

  logic                           op_valid, op_ready;
  op_t                            op;
  logic                           res_valid, out_full;
  res_t                           res;
  logic [$bits(res_t)-1:0]        out_rdata;
  res_t                           out_item;
  logic [$clog2(OUT_DEPTH+1)-1:0] out_count;

  // accept and classify items
  wpm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .kind_i      (kind_i),
    .char_value_i(char_value_i),
    .op_valid_o  (op_valid),
    .op_o        (op),
    .op_ready_i  (op_ready)
  );

  // carry out pattern loads and window compares
  wpm_back #(
    .MAX_PATTERN  (MAX_PATTERN),
    .POSITION_BITS(POSITION_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (op_valid),
    .op_i       (op),
    .op_ready_o (op_ready),
    .out_count_i(out_count),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // result queue toward the consumer
  wpm_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_valid),
    .data_i (res),
    .pop_i  (pop),
    .data_o (out_rdata),
    .full_o (out_full),
    .empty_o(empty),
    .count_o(out_count)
  );

  assign out_item         = res_t'(out_rdata);
  assign match_start_o    = out_item.match_start;
  assign overflow_error_o = out_item.overflow_error;

  // assertions
  a_no_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !out_full)
    else $error("result written into a full result queue");
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty)
    else $error("waiting result vanished without a pop");
  a_result_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && overflow_error_o |-> match_start_o == '0)
    else $error("overflow result carries a start index");

endmodule

@@ bench/tb_top.sv @@
// self-checking testbench of the wildcard pattern matcher top level
module tb_top;
  import wpm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WIN_SIZE    = MAX_PATTERN_DEF;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned RAND_ITEMS  = 1150;
  localparam res_t        NO_MATCH    = '0;
  localparam res_t        PAT_OVERRUN = res_t'{32'd0, 1'b1};
  // kind code that the block ignores
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // directed row: an item repeated reps times, with an optional typed-in result
  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] ch;
    int unsigned       reps;
    bit                typed;
    bit                has_res;
    res_t              res;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                push;
  logic                full;
  logic [KIND_W-1:0]   kind_i;
  logic [CHAR_W-1:0]   char_value_i;
  logic                empty;
  logic                pop;
  logic [START_W-1:0]  match_start_o;
  logic                overflow_error_o;

  // predictor state
  logic [CHAR_W-1:0]   pat_mem [WIN_SIZE];
  int unsigned         pat_len;
  logic [CHAR_W-1:0]   txt_ring [WIN_SIZE];
  longint unsigned     txt_cnt;

  res_t                pending_matches [$];
  int unsigned         mismatch_cnt;
  int unsigned         sent_items;
  bit                  snd_fast;
  bit                  hold_req;

  wildcard_pattern_matcher_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .kind_i           (kind_i),
    .char_value_i     (char_value_i),
    .empty            (empty),
    .pop              (pop),
    .match_start_o    (match_start_o),
    .overflow_error_o (overflow_error_o)
  );

  // directed stimulus
  dir_row_t dir_tab [] = '{
    '{KIND_RESTART, 8'h00, 1, 1'b1, 1'b0, NO_MATCH},
    // text with an empty pattern never matches
    '{KIND_TEXT,    8'h00, 1, 1'b1, 1'b0, NO_MATCH},
    '{KIND_TEXT,    8'hFF, 1, 1'b1, 1'b0, NO_MATCH},
    '{KIND_APPEND,  8'h41, 1, 1'b0, 1'b0, NO_MATCH},
    '{KIND_APPEND,  WILDCARD_CHAR, 1, 1'b0, 1'b0, NO_MATCH},
    '{KIND_APPEND,  8'hFF, 1, 1'b0, 1'b0, NO_MATCH},
    '{KIND_TEXT,    8'h41, 1, 1'b0, 1'b0, NO_MATCH},
    '{KIND_TEXT,    8'h00, 1, 1'b0, 1'b0, NO_MATCH},
    '{KIND_TEXT,    8'hFF, 1, 1'b0, 1'b0, NO_MATCH},
    '{KIND_TEXT,    8'h41, 1, 1'b0, 1'b0, NO_MATCH},
    // single wildcard pattern, then a pattern byte after text
    '{KIND_RESTART, 8'hFF, 1, 1'b1, 1'b0, NO_MATCH},
    '{KIND_APPEND,  WILDCARD_CHAR, 1, 1'b0, 1'b0, NO_MATCH},
    '{KIND_TEXT,    8'h00, 1, 1'b0, 1'b0, NO_MATCH},
    '{KIND_TEXT,    8'hFF, 1, 1'b0, 1'b0, NO_MATCH},
    '{KIND_APPEND,  8'h80, 1, 1'b0, 1'b0, NO_MATCH},
    '{KIND_TEXT,    8'h80, 1, 1'b0, 1'b0, NO_MATCH},
    '{KIND_TEXT,    8'h7F, 1, 1'b0, 1'b0, NO_MATCH},
    // unused kind is dropped
    '{KIND_UNUSED,  8'hAA, 1, 1'b1, 1'b0, NO_MATCH},
    // full-size pattern, overrun, then full-size windows
    '{KIND_RESTART, 8'h55, 1, 1'b1, 1'b0, NO_MATCH},
    '{KIND_APPEND,  8'h00, WIN_SIZE - 1, 1'b0, 1'b0, NO_MATCH},
    '{KIND_APPEND,  WILDCARD_CHAR, 1, 1'b0, 1'b0, NO_MATCH},
    '{KIND_APPEND,  8'h01, 1, 1'b1, 1'b1, PAT_OVERRUN},
    '{KIND_APPEND,  8'hFE, 1, 1'b1, 1'b1, PAT_OVERRUN},
    '{KIND_TEXT,    8'h00, WIN_SIZE - 1, 1'b0, 1'b0, NO_MATCH},
    '{KIND_TEXT,    8'h7F, 2, 1'b0, 1'b0, NO_MATCH}
  };

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // works out the result of one accepted item and advances the predictor
  function automatic bit predict_match(input logic [KIND_W-1:0] k,
                                       input logic [CHAR_W-1:0] c, output res_t r);
    longint unsigned idx;
    longint unsigned start;
    logic [CHAR_W-1:0] p;
    r = NO_MATCH;
    case (k)
      KIND_RESTART: begin
        pat_len = 0;
        txt_cnt = 0;
        foreach (txt_ring[i]) txt_ring[i] = '0;
        return 1'b0;
      end
      KIND_APPEND: begin
        if (pat_len >= WIN_SIZE) begin
          r.overflow_error = 1'b1;
          return 1'b1;
        end
        pat_mem[pat_len] = c;
        pat_len++;
        return 1'b0;
      end
      KIND_TEXT: begin
        idx = txt_cnt;
        if (idx >= (64'd1 << POSITION_BITS_DEF) - 1) return 1'b0;
        txt_ring[idx % WIN_SIZE] = c;
        txt_cnt = idx + 1;
        if (pat_len == 0 || idx + 1 < pat_len) return 1'b0;
        start = idx + 1 - pat_len;
        // compare every pattern lane against the window
        for (int unsigned j = 0; j < pat_len; j++) begin
          p = pat_mem[j];
          if (p != WILDCARD_CHAR && p != txt_ring[(start + j) % WIN_SIZE]) return 1'b0;
        end
        r.match_start = start[START_W-1:0];
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // offers one item, waits for acceptance, records the expected result
  task automatic send_item(input logic [KIND_W-1:0] k, input logic [CHAR_W-1:0] c,
                           input bit typed = 1'b0, input bit t_has = 1'b0,
                           input res_t t_res = '0);
    int unsigned gap;
    bit          has;
    res_t        r;
    gap = snd_fast ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push         <= 1'b1;
    kind_i       <= k;
    char_value_i <= c;
    do @(posedge clk_i); while (full);
    has = predict_match(k, c, r);
    if (typed) begin
      has = t_has;
      r   = t_res;
    end
    if (has) pending_matches = {pending_matches, r};
    if (k != KIND_UNUSED) sent_items++;
  endtask

  // stalls the sender until every expected result has come back
  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk_i); while (pending_matches.size() != 0);
  endtask

  // picks a byte from a two-letter alphabet
  function automatic logic [CHAR_W-1:0] pick2(input logic [CHAR_W-1:0] a,
                                              input logic [CHAR_W-1:0] b);
    return $urandom_range(0, 1) ? a : b;
  endfunction

  // one random sequence: mostly a clean pattern then text, some noise and broken runs
  task automatic run_sequence();
    int unsigned       sel;
    int unsigned       plen;
    int unsigned       tlen;
    int unsigned       eff;
    logic [CHAR_W-1:0] a;
    logic [CHAR_W-1:0] b;
    sel      = $urandom_range(0, 9);
    snd_fast = ($urandom_range(0, 3) == 0);
    a        = 8'($urandom);
    b        = 8'($urandom);
    if (sel < 8) begin
      plen = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 67) : $urandom_range(1, 6);
      eff  = (plen > WIN_SIZE) ? WIN_SIZE : plen;
      tlen = $urandom_range(eff, eff + 30);
      send_item(KIND_RESTART, 8'($urandom));
      repeat (plen)
        send_item(KIND_APPEND, ($urandom_range(0, 3) == 0) ? WILDCARD_CHAR : pick2(a, b));
      repeat (tlen) begin
        if ($urandom_range(0, 39) == 0) send_item(KIND_APPEND, pick2(a, WILDCARD_CHAR));
        send_item(KIND_TEXT, ($urandom_range(0, 15) == 0) ? 8'($urandom) : pick2(a, b));
      end
    end else if (sel == 8) begin
      // noise on every kind and byte
      repeat (12) send_item(2'($urandom_range(0, 3)), 8'($urandom));
    end else begin
      // no restart: extend whatever pattern is there, or text alone
      if ($urandom_range(0, 1)) repeat ($urandom_range(1, 3)) send_item(KIND_APPEND, pick2(a, b));
      repeat ($urandom_range(1, 10)) send_item(KIND_TEXT, pick2(a, b));
    end
  endtask

  // result side: random stalls, one long hold on request
  initial begin
    int unsigned stall_left;
    res_t        exp_r;
    stall_left = 0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        if (pending_matches.size() == 0) begin
          $display("%0t: unexpected item start=%0d ovf=%0b", $time, match_start_o,
                   overflow_error_o);
          mismatch_cnt++;
        end else begin
          exp_r = pending_matches.pop_front();
          if (match_start_o !== exp_r.match_start) begin
            $display("%0t: match_start expected %0d actual %0d", $time,
                     exp_r.match_start, match_start_o);
            mismatch_cnt++;
          end
          if (overflow_error_o !== exp_r.overflow_error) begin
            $display("%0t: overflow_error expected %0b actual %0b", $time,
                     exp_r.overflow_error, overflow_error_o);
            mismatch_cnt++;
          end
        end
        stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      end
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // stimulus and end of run
  initial begin
    rst_ni       = 1'b0;
    push         = 1'b0;
    pop          = 1'b0;
    kind_i       = KIND_RESTART;
    char_value_i = '0;
    pat_len      = 0;
    txt_cnt      = 0;
    foreach (pat_mem[i]) pat_mem[i] = '0;
    foreach (txt_ring[i]) txt_ring[i] = '0;
    mismatch_cnt = 0;
    sent_items   = 0;
    snd_fast     = 1'b0;
    hold_req     = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (dir_tab[r]) begin
      snd_fast = (r % 3 == 0);
      repeat (dir_tab[r].reps)
        send_item(dir_tab[r].kind, dir_tab[r].ch, dir_tab[r].typed,
                  dir_tab[r].has_res, dir_tab[r].res);
    end
    wait_drained();

    // back-pressure: result side held while every text byte matches
    snd_fast = 1'b1;
    send_item(KIND_RESTART, 8'h00);
    send_item(KIND_APPEND, WILDCARD_CHAR);
    hold_req = 1'b1;
    repeat (40) send_item(KIND_TEXT, 8'($urandom));
    wait_drained();

    // random sequences
    sent_items = 0;
    while (sent_items < RAND_ITEMS) begin
      run_sequence();
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
